[hdl/mexp_pkg.sv]
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, datapath command codes, control/status types and the
// modular add used by the square-and-multiply datapath.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W         = $clog2(OPERAND_WIDTH);
  localparam int CMD_W         = 3;

  localparam logic [OPERAND_WIDTH-1:0] MOD_RESET = OPERAND_WIDTH'(23);

  // datapath commands
  localparam logic [CMD_W-1:0] CMD_NOP         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIV_STEP    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV_END     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MUL_R_START = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MUL_B_START = 3'd5;
  localparam logic [CMD_W-1:0] CMD_MUL_STEP    = 3'd6;
  localparam logic [CMD_W-1:0] CMD_MUL_END     = 3'd7;

  typedef logic [OPERAND_WIDTH-1:0] word_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             res_end;   // with CMD_MUL_END: product goes to result, else to base
    logic             out_load;  // load the output register
  } dp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
    logic out_busy;
  } dp_status_t;

  // (a + b) mod m for a < m and b < m
  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    logic [OPERAND_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[OPERAND_WIDTH-1:0];
  endfunction

endpackage

[hdl/mexp_ifs.sv]
// ----------------------------------------------------------------------------
// mexp channel interfaces
// Valid/ready channels for the input item, the result item and the
// modulus configuration write.
// ----------------------------------------------------------------------------
interface mexp_in_if import mexp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t base_value;
  word_t exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t power_result;
  logic  modulus_error;

  modport source (output valid, output power_result, output modulus_error, input ready);
  modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

[hdl/modular_exponentiation.sv]
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base_value ^ exponent mod modulus by right-to-left square and
// multiply, with a configurable modulus.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : item with base_value and exponent, taken when valid && ready.
//   out_ch : item with power_result and modulus_error, one per input item.
//   cfg_ch : modulus write, always ready; write it only while the block is
//            idle. Reset loads a modulus of 23.
// A zero modulus gives modulus_error = 1 and power_result = 0; a zero
// exponent gives 1 without reduction.
// One item at a time. The base is first reduced by restoring remainder
// steps; each exponent bit up to the highest set one then takes a square
// or a multiply and a square, all on the one shared bit-serial modular
// multiplier. A zero modulus skips both and goes straight to the result.
// in_ch.ready is high only while idle; a finished item waits in the output
// register, and the next item may be accepted while it does. If the receiver
// stalls, the following result is held until the output register frees up.
// Reset is synchronous, active low, and drops any item in flight.
// ----------------------------------------------------------------------------
module modular_exponentiation import mexp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mexp_in_if.sink   in_ch,
  mexp_out_if.source out_ch,
  mexp_cfg_if.sink  cfg_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mexp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_base_value     (in_ch.base_value),
    .in_exponent       (in_ch.exponent),
    .cfg_we            (cfg_ch.valid),
    .cfg_modulus       (cfg_ch.modulus),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_power_result  (out_ch.power_result),
    .out_modulus_error (out_ch.modulus_error)
  );

endmodule

[hdl/mexp_ctrl.sv]
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for square-and-multiply: base reduction, per exponent bit an
// optional multiply and a square, then the result handoff.
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DIV      = 4'd1;
  localparam logic [3:0] S_DIV_END  = 4'd2;
  localparam logic [3:0] S_BIT      = 4'd3;
  localparam logic [3:0] S_MUL_R    = 4'd4;
  localparam logic [3:0] S_RES_END  = 4'd5;
  localparam logic [3:0] S_MUL_B    = 4'd6;
  localparam logic [3:0] S_BASE_END = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(OPERAND_WIDTH - 1));
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = '0;
    cmd.op       = CMD_NOP;
    cmd.res_end  = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          state_nxt = status.mod_zero ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        cmd.op  = CMD_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.op    = CMD_DIV_END;
        state_nxt = S_BIT;
      end
      S_BIT: begin
        priority if (status.exp_zero) begin
          state_nxt = S_OUT;
        end else if (status.exp_lsb) begin
          cmd.op    = CMD_MUL_R_START;
          state_nxt = S_MUL_R;
        end else begin
          cmd.op    = CMD_MUL_B_START;
          state_nxt = S_MUL_B;
        end
      end
      S_MUL_R, S_MUL_B: begin
        cmd.op  = CMD_MUL_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = (state_r == S_MUL_R) ? S_RES_END : S_BASE_END;
        end
      end
      S_RES_END: begin
        // store result and set up the square in one go
        cmd.op      = CMD_MUL_END;
        cmd.res_end = 1'b1;
        state_nxt   = S_MUL_B;
      end
      S_BASE_END: begin
        cmd.op    = CMD_MUL_END;
        state_nxt = S_BIT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hdl/mexp_dp.sv]
// ----------------------------------------------------------------------------
// mexp_dp
// Operand registers, shared bit-serial modular multiplier / reducer,
// modulus register and output register.
// ----------------------------------------------------------------------------
module mexp_dp import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  word_t      in_base_value,
  input  word_t      in_exponent,
  input  logic       cfg_we,
  input  word_t      cfg_modulus,
  input  logic       out_ready,
  output logic       out_valid,
  output word_t      out_power_result,
  output logic       out_modulus_error
);

  word_t mod_r;
  word_t base_r, base_nxt;
  word_t res_r, res_nxt;
  word_t exp_r, exp_nxt;
  word_t ma_r, ma_nxt;
  word_t mb_r, mb_nxt;
  word_t acc_r, acc_nxt;
  word_t out_res_r;
  logic  out_err_r;
  logic  out_valid_r, out_valid_nxt;

  logic [OPERAND_WIDTH:0] div_trial;
  word_t                  res_op;

  // result is 1 (unreduced) or already below the modulus
  assign res_op = (res_r >= mod_r) ? '0 : res_r;

  always_comb begin
    div_trial = {acc_r, mb_r[OPERAND_WIDTH-1]};
    if (div_trial >= {1'b0, mod_r}) begin
      div_trial = div_trial - {1'b0, mod_r};
    end
  end

  always_comb begin
    base_nxt = base_r;
    res_nxt  = res_r;
    exp_nxt  = exp_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    unique case (cmd.op)
      CMD_NOP: begin
      end
      CMD_LOAD: begin
        mb_nxt  = in_base_value;
        exp_nxt = in_exponent;
        res_nxt = OPERAND_WIDTH'(1);
        acc_nxt = '0;
      end
      CMD_DIV_STEP: begin
        acc_nxt = div_trial[OPERAND_WIDTH-1:0];
        mb_nxt  = {mb_r[OPERAND_WIDTH-2:0], 1'b0};
      end
      CMD_DIV_END: begin
        base_nxt = acc_r;
      end
      CMD_MUL_R_START: begin
        ma_nxt  = base_r;
        mb_nxt  = res_op;
        acc_nxt = '0;
      end
      CMD_MUL_B_START: begin
        ma_nxt  = base_r;
        mb_nxt  = base_r;
        acc_nxt = '0;
      end
      CMD_MUL_STEP: begin
        if (mb_r[0]) begin
          acc_nxt = add_mod(acc_r, ma_r, mod_r);
        end
        ma_nxt = add_mod(ma_r, ma_r, mod_r);
        mb_nxt = {1'b0, mb_r[OPERAND_WIDTH-1:1]};
      end
      CMD_MUL_END: begin
        if (cmd.res_end) begin
          res_nxt = acc_r;
          ma_nxt  = base_r;
          mb_nxt  = base_r;
          acc_nxt = '0;
        end else begin
          base_nxt = acc_r;
          exp_nxt  = {1'b0, exp_r[OPERAND_WIDTH-1:1]};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MOD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mod_r <= cfg_modulus;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    res_r  <= res_nxt;
    exp_r  <= exp_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    if (cmd.out_load) begin
      out_err_r <= (mod_r == '0);
      out_res_r <= (mod_r == '0) ? '0 : res_r;
    end
  end

  assign status.exp_zero = (exp_r == '0);
  assign status.exp_lsb  = exp_r[0];
  assign status.mod_zero = (mod_r == '0);
  assign status.out_busy = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_power_result  = out_res_r;
  assign out_modulus_error = out_err_r;

endmodule

[hdl/mexp_chk.sv]
// ----------------------------------------------------------------------------
// mexp_chk
// Port-level checks for modular_exponentiation, attached by bind.
// ----------------------------------------------------------------------------
module mexp_chk import mexp_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_power_result,
  input logic  out_modulus_error
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: input closes after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // error result carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_modulus_error) |-> (out_power_result == '0))
    else $error("modulus error with nonzero result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_power_result)
                                   && $stable(out_modulus_error)))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation mexp_chk u_mexp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_power_result  (out_ch.power_result),
  .out_modulus_error (out_ch.modulus_error)
);
